[rtl/ble_adv_pkg.sv]
// Package with AD type codes and the result record of the advertising data parser.
`timescale 1ns / 1ps

package ble_adv_pkg;

  localparam logic [7:0] TYPE_FLAGS       = 8'h01;
  localparam logic [7:0] TYPE_UUID16_SOME = 8'h02;
  localparam logic [7:0] TYPE_UUID16_ALL  = 8'h03;
  localparam logic [7:0] TYPE_NAME_SHORT  = 8'h08;
  localparam logic [7:0] TYPE_NAME_FULL   = 8'h09;
  localparam logic [7:0] TYPE_APPEARANCE  = 8'h19;
  localparam logic [15:0] UUID_HID        = 16'h1812;
  localparam logic [9:0] HID_CATEGORY     = 10'd15;

  localparam int unsigned RESULT_BITS = 44;
  localparam int unsigned RESULT_TDATA_W = 48;

  typedef struct packed {
    logic       name_is_full;
    logic [7:0] name_length;
    logic [7:0] name_offset;
    logic       name_found;
    logic [7:0] adv_flags;
    logic       flags_present;
    logic [15:0] appearance;
    logic       is_hid;
  } result_t;

endpackage

[rtl/ble_adv_data_parser.sv]
// Top level of the BLE advertising data parser: AD structure walk and summary output.
// The summary is written into the result buffer when the last byte is accepted.
// Throughput: one advertising byte per cycle while s_tready is high; a single registered pass.
// A two-entry result buffer keeps input flowing while one summary waits to be taken.
// Reset (rst, synchronous, active high) clears the parse state and empties the buffer.
// After each summary the parse state returns to its reset values for the next packet.
`timescale 1ns / 1ps

module ble_adv_data_parser #(
  parameter int unsigned MAX_PACKET_BYTES = 255
) (
  input  logic        clk,
  input  logic        rst,
  input  logic        s_tvalid,
  output logic        s_tready,
  input  logic [7:0]  s_tdata,   // data_byte[7:0]
  input  logic        s_tlast,   // last_byte
  output logic        m_tvalid,
  input  logic        m_tready,
  output logic [ble_adv_pkg::RESULT_TDATA_W-1:0] m_tdata
  // m_tdata fields from bit 0: is_hid, appearance[15:0], flags_present, adv_flags[7:0],
  // name_found, name_offset[7:0], name_length[7:0], name_is_full, zero fill.
);

  import ble_adv_pkg::*;

  localparam int unsigned POS_W = $clog2(MAX_PACKET_BYTES + 1);
  localparam logic [POS_W-1:0] POS_MAX = POS_W'(MAX_PACKET_BYTES);

  logic [POS_W-1:0] byte_position, byte_position_next;
  logic [7:0]  bytes_left, bytes_left_next;
  logic [7:0]  field_kind, field_kind_next;
  logic [7:0]  payload_index, payload_index_next;
  logic [7:0]  held_low_byte, held_low_byte_next;
  logic        parse_stopped, parse_stopped_next;
  logic [15:0] pending_value, pending_value_next;
  logic        pending_hit, pending_hit_next;
  logic        hid_seen, hid_seen_next;
  logic [15:0] appearance_value, appearance_value_next;
  logic        flags_seen, flags_seen_next;
  logic [7:0]  flags_value, flags_value_next;
  logic        name_seen, name_seen_next;
  logic [7:0]  name_start, name_start_next;
  logic [7:0]  name_size, name_size_next;
  logic        name_is_complete, name_is_complete_next;

  result_t     result_new;
  result_t     slot0, slot1;
  logic [1:0]  count;
  logic        accept, push, pop;
  logic [7:0]  k;

  assign s_tready = (count != 2'd2);
  assign accept   = s_tvalid && s_tready;
  assign push     = accept && s_tlast;
  assign m_tvalid = (count != 2'd0);
  assign pop      = m_tvalid && m_tready;
  assign m_tdata  = {{(RESULT_TDATA_W - RESULT_BITS){1'b0}}, slot0};

  always_comb begin
    byte_position_next    = byte_position;
    bytes_left_next       = bytes_left;
    field_kind_next       = field_kind;
    payload_index_next    = payload_index;
    held_low_byte_next    = held_low_byte;
    parse_stopped_next    = parse_stopped;
    pending_value_next    = pending_value;
    pending_hit_next      = pending_hit;
    hid_seen_next         = hid_seen;
    appearance_value_next = appearance_value;
    flags_seen_next       = flags_seen;
    flags_value_next      = flags_value;
    name_seen_next        = name_seen;
    name_start_next       = name_start;
    name_size_next        = name_size;
    name_is_complete_next = name_is_complete;
    k                     = payload_index - 8'd1;
    result_new            = '0;

    if (accept) begin
      if (!parse_stopped && (byte_position < POS_MAX)) begin
        if (bytes_left == 8'd0) begin
          if (s_tdata == 8'd0) begin
            parse_stopped_next = 1'b1;
          end else begin
            bytes_left_next    = s_tdata;
            payload_index_next = 8'd0;
          end
        end else begin
          if (payload_index == 8'd0) begin
            field_kind_next    = s_tdata;
            pending_hit_next   = 1'b0;
            pending_value_next = 16'(byte_position) + 16'd1;
          end else begin
            unique case (field_kind) inside
              TYPE_FLAGS: begin
                if (k == 8'd0) begin
                  pending_value_next = {8'd0, s_tdata};
                  pending_hit_next   = 1'b1;
                end
              end
              TYPE_UUID16_SOME, TYPE_UUID16_ALL: begin
                if (!k[0]) begin
                  held_low_byte_next = s_tdata;
                end else if ({s_tdata, held_low_byte} == UUID_HID) begin
                  pending_hit_next = 1'b1;
                end
              end
              TYPE_APPEARANCE: begin
                if (k == 8'd0) begin
                  held_low_byte_next = s_tdata;
                end else if (k == 8'd1) begin
                  pending_value_next = {s_tdata, held_low_byte};
                  pending_hit_next   = 1'b1;
                end
              end
              default: begin
              end
            endcase
          end
          payload_index_next = payload_index + 8'd1;
          bytes_left_next    = bytes_left - 8'd1;

          // The structure completes on this byte, so its pending effects take hold.
          if (bytes_left == 8'd1) begin
            unique case (field_kind_next) inside
              TYPE_FLAGS: begin
                if (pending_hit_next) begin
                  flags_seen_next  = 1'b1;
                  flags_value_next = pending_value_next[7:0];
                end
              end
              TYPE_UUID16_SOME, TYPE_UUID16_ALL: begin
                if (pending_hit_next) begin
                  hid_seen_next = 1'b1;
                end
              end
              TYPE_NAME_SHORT, TYPE_NAME_FULL: begin
                if (!name_seen || (field_kind_next == TYPE_NAME_FULL && !name_is_complete)) begin
                  name_seen_next        = 1'b1;
                  name_start_next       = pending_value_next[7:0];
                  name_size_next        = payload_index;
                  name_is_complete_next = (field_kind_next == TYPE_NAME_FULL);
                end
              end
              TYPE_APPEARANCE: begin
                if (pending_hit_next) begin
                  appearance_value_next = pending_value_next;
                  if (pending_value_next[15:6] == HID_CATEGORY) begin
                    hid_seen_next = 1'b1;
                  end
                end
              end
              default: begin
              end
            endcase
          end
        end
      end

      if (byte_position < POS_MAX) begin
        byte_position_next = byte_position + POS_W'(1);
      end

      if (s_tlast) begin
        result_new.is_hid        = hid_seen_next;
        result_new.appearance    = appearance_value_next;
        result_new.flags_present = flags_seen_next;
        result_new.adv_flags     = flags_value_next;
        result_new.name_found    = name_seen_next;
        result_new.name_offset   = name_start_next;
        result_new.name_length   = name_size_next;
        result_new.name_is_full  = name_is_complete_next;

        byte_position_next    = '0;
        bytes_left_next       = '0;
        field_kind_next       = '0;
        payload_index_next    = '0;
        held_low_byte_next    = '0;
        parse_stopped_next    = 1'b0;
        pending_value_next    = '0;
        pending_hit_next      = 1'b0;
        hid_seen_next         = 1'b0;
        appearance_value_next = '0;
        flags_seen_next       = 1'b0;
        flags_value_next      = '0;
        name_seen_next        = 1'b0;
        name_start_next       = '0;
        name_size_next        = '0;
        name_is_complete_next = 1'b0;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      byte_position    <= '0;
      bytes_left       <= '0;
      field_kind       <= '0;
      payload_index    <= '0;
      held_low_byte    <= '0;
      parse_stopped    <= 1'b0;
      pending_value    <= '0;
      pending_hit      <= 1'b0;
      hid_seen         <= 1'b0;
      appearance_value <= '0;
      flags_seen       <= 1'b0;
      flags_value      <= '0;
      name_seen        <= 1'b0;
      name_start       <= '0;
      name_size        <= '0;
      name_is_complete <= 1'b0;
    end else begin
      byte_position    <= byte_position_next;
      bytes_left       <= bytes_left_next;
      field_kind       <= field_kind_next;
      payload_index    <= payload_index_next;
      held_low_byte    <= held_low_byte_next;
      parse_stopped    <= parse_stopped_next;
      pending_value    <= pending_value_next;
      pending_hit      <= pending_hit_next;
      hid_seen         <= hid_seen_next;
      appearance_value <= appearance_value_next;
      flags_seen       <= flags_seen_next;
      flags_value      <= flags_value_next;
      name_seen        <= name_seen_next;
      name_start       <= name_start_next;
      name_size        <= name_size_next;
      name_is_complete <= name_is_complete_next;
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      count <= 2'd0;
    end else begin
      case ({push, pop})
        2'b10: count <= count + 2'd1;
        2'b01: count <= count - 2'd1;
        default: count <= count;
      endcase
    end
  end

  always_ff @(posedge clk) begin
    if (push && pop) begin
      if (count == 2'd1) begin
        slot0 <= result_new;
      end else begin
        slot0 <= slot1;
        slot1 <= result_new;
      end
    end else if (push) begin
      if (count == 2'd0) begin
        slot0 <= result_new;
      end else begin
        slot1 <= result_new;
      end
    end else if (pop) begin
      slot0 <= slot1;
    end
  end

endmodule

[dv/ble_adv_data_parser_tb.sv]
// Self-checking testbench for the BLE advertising data parser with a built-in packet predictor.
`timescale 1ns / 1ps

module ble_adv_data_parser_tb;
  import ble_adv_pkg::*;

  localparam int unsigned PKT_WINDOW = 255;
  localparam int LONG_HOLD = 300;
  localparam int PHASE_BYTES = 250;

  typedef struct packed {
    logic [7:0] data;
    logic       last;
    logic       typed;
    result_t    want;
  } dir_row_t;

  typedef struct {
    int unsigned pos;
    logic [7:0]  remain;
    logic [7:0]  kind;
    logic [7:0]  idx;
    logic [7:0]  low_hold;
    logic        stopped;
    logic [15:0] pend_val;
    logic        pend_hit;
    logic        hid;
    logic [15:0] appear;
    logic        flags_ok;
    logic [7:0]  flags_byte;
    logic        name_ok;
    logic [7:0]  name_at;
    logic [7:0]  name_bytes;
    logic        name_full;
  } adv_state_t;

  localparam result_t NONE_SEEN = '0;
  localparam result_t FLAGS_FF = '{is_hid: 1'b0, appearance: 16'h0000, flags_present: 1'b1,
                                   adv_flags: 8'hFF, name_found: 1'b0, name_offset: 8'h00,
                                   name_length: 8'h00, name_is_full: 1'b0};
  localparam result_t HID_APPEAR = '{is_hid: 1'b1, appearance: 16'h03C1, flags_present: 1'b0,
                                     adv_flags: 8'h00, name_found: 1'b0, name_offset: 8'h00,
                                     name_length: 8'h00, name_is_full: 1'b0};
  localparam result_t NAME_EMPTY = '{is_hid: 1'b0, appearance: 16'h0000, flags_present: 1'b0,
                                     adv_flags: 8'h00, name_found: 1'b1, name_offset: 8'h02,
                                     name_length: 8'h00, name_is_full: 1'b1};

  localparam int DIR_ROWS = 25;
  localparam dir_row_t DIRECTED [DIR_ROWS] = '{
    '{8'h00, 1'b1, 1'b1, NONE_SEEN},
    '{8'h02, 1'b0, 1'b0, NONE_SEEN},
    '{TYPE_FLAGS, 1'b0, 1'b0, NONE_SEEN},
    '{8'hFF, 1'b1, 1'b1, FLAGS_FF},
    '{8'h03, 1'b0, 1'b0, NONE_SEEN},
    '{TYPE_APPEARANCE, 1'b0, 1'b0, NONE_SEEN},
    '{8'hC1, 1'b0, 1'b0, NONE_SEEN},
    '{8'h03, 1'b1, 1'b1, HID_APPEAR},
    '{8'h01, 1'b0, 1'b0, NONE_SEEN},
    '{TYPE_NAME_FULL, 1'b1, 1'b1, NAME_EMPTY},
    '{8'h04, 1'b0, 1'b0, NONE_SEEN},
    '{TYPE_UUID16_ALL, 1'b0, 1'b0, NONE_SEEN},
    '{8'h12, 1'b0, 1'b0, NONE_SEEN},
    '{8'h18, 1'b0, 1'b0, NONE_SEEN},
    '{8'h7F, 1'b1, 1'b0, NONE_SEEN},
    '{8'h02, 1'b0, 1'b0, NONE_SEEN},
    '{TYPE_NAME_SHORT, 1'b0, 1'b0, NONE_SEEN},
    '{8'h41, 1'b0, 1'b0, NONE_SEEN},
    '{8'h03, 1'b0, 1'b0, NONE_SEEN},
    '{TYPE_NAME_FULL, 1'b0, 1'b0, NONE_SEEN},
    '{8'h42, 1'b0, 1'b0, NONE_SEEN},
    '{8'h43, 1'b1, 1'b0, NONE_SEEN},
    '{8'h05, 1'b0, 1'b0, NONE_SEEN},
    '{TYPE_APPEARANCE, 1'b0, 1'b0, NONE_SEEN},
    '{8'hC1, 1'b1, 1'b1, NONE_SEEN}
  };

  logic clk = 1'b0;
  logic rst = 1'b1;
  logic s_tvalid = 1'b0;
  logic s_tready;
  logic [7:0] s_tdata = 8'h00;
  logic s_tlast = 1'b0;
  logic m_tvalid;
  logic m_tready = 1'b0;
  logic [RESULT_TDATA_W-1:0] m_tdata;

  logic cur_typed = 1'b0;
  result_t cur_want = '0;

  adv_state_t pkt_st = '{default: '0};
  result_t summaries_due[$];
  logic [7:0] pkt_bytes[$];

  int fails = 0;
  int src_idle_pct = 0;
  int snk_stall_pct = 0;
  logic hold_go = 1'b0;
  int hold_cnt = 0;
  int bytes_taken = 0;
  int sums_checked = 0;
  int hid_sums = 0;
  int named_sums = 0;
  int packets_sent = 0;
  int long_packets = 0;

  ble_adv_data_parser #(
    .MAX_PACKET_BYTES(PKT_WINDOW)
  ) i_dut (
    .clk(clk),
    .rst(rst),
    .s_tvalid(s_tvalid),
    .s_tready(s_tready),
    .s_tdata(s_tdata),
    .s_tlast(s_tlast),
    .m_tvalid(m_tvalid),
    .m_tready(m_tready),
    .m_tdata(m_tdata)
  );

  always #1 clk = ~clk;

  function automatic void close_field();
    case (pkt_st.kind)
      TYPE_FLAGS: begin
        if (pkt_st.pend_hit) begin
          pkt_st.flags_ok = 1'b1;
          pkt_st.flags_byte = pkt_st.pend_val[7:0];
        end
      end
      TYPE_UUID16_SOME, TYPE_UUID16_ALL: begin
        if (pkt_st.pend_hit) pkt_st.hid = 1'b1;
      end
      TYPE_NAME_SHORT, TYPE_NAME_FULL: begin
        if (!pkt_st.name_ok || (pkt_st.kind == TYPE_NAME_FULL && !pkt_st.name_full)) begin
          pkt_st.name_ok = 1'b1;
          pkt_st.name_at = pkt_st.pend_val[7:0];
          pkt_st.name_bytes = pkt_st.idx - 8'd1;
          pkt_st.name_full = (pkt_st.kind == TYPE_NAME_FULL);
        end
      end
      TYPE_APPEARANCE: begin
        if (pkt_st.pend_hit) begin
          pkt_st.appear = pkt_st.pend_val;
          if (pkt_st.pend_val[15:6] == HID_CATEGORY) pkt_st.hid = 1'b1;
        end
      end
      default: ;
    endcase
  endfunction

  function automatic void walk_ad_byte(input logic [7:0] b);
    logic [7:0] k;
    if (pkt_st.remain == 8'd0) begin
      if (b == 8'd0) begin
        pkt_st.stopped = 1'b1;
      end else begin
        pkt_st.remain = b;
        pkt_st.idx = 8'd0;
      end
      return;
    end
    if (pkt_st.idx == 8'd0) begin
      pkt_st.kind = b;
      pkt_st.pend_hit = 1'b0;
      pkt_st.pend_val = 16'(pkt_st.pos + 1);
    end else begin
      k = pkt_st.idx - 8'd1;
      case (pkt_st.kind)
        TYPE_FLAGS: begin
          if (k == 8'd0) begin
            pkt_st.pend_val = {8'h00, b};
            pkt_st.pend_hit = 1'b1;
          end
        end
        TYPE_UUID16_SOME, TYPE_UUID16_ALL: begin
          if (!k[0]) pkt_st.low_hold = b;
          else if ({b, pkt_st.low_hold} == UUID_HID) pkt_st.pend_hit = 1'b1;
        end
        TYPE_APPEARANCE: begin
          if (k == 8'd0) begin
            pkt_st.low_hold = b;
          end else if (k == 8'd1) begin
            pkt_st.pend_val = {b, pkt_st.low_hold};
            pkt_st.pend_hit = 1'b1;
          end
        end
        default: ;
      endcase
    end
    pkt_st.idx = pkt_st.idx + 8'd1;
    pkt_st.remain = pkt_st.remain - 8'd1;
    if (pkt_st.remain == 8'd0) close_field();
  endfunction

  function automatic bit predict_summary(input logic [7:0] b, input logic l,
                                         output result_t sum);
    if (!pkt_st.stopped && pkt_st.pos < PKT_WINDOW) walk_ad_byte(b);
    if (pkt_st.pos < PKT_WINDOW) pkt_st.pos++;
    sum = '0;
    if (!l) return 1'b0;
    sum.is_hid = pkt_st.hid;
    sum.appearance = pkt_st.appear;
    sum.flags_present = pkt_st.flags_ok;
    sum.adv_flags = pkt_st.flags_ok ? pkt_st.flags_byte : 8'h00;
    sum.name_found = pkt_st.name_ok;
    sum.name_offset = pkt_st.name_ok ? pkt_st.name_at : 8'h00;
    sum.name_length = pkt_st.name_ok ? pkt_st.name_bytes : 8'h00;
    sum.name_is_full = pkt_st.name_ok && pkt_st.name_full;
    pkt_st = '{default: '0};
    return 1'b1;
  endfunction

  function automatic void check_field(input string label, input int unsigned want,
                                      input int unsigned got);
    if (want != got) begin
      $error("%s mismatch: expected 0x%0h, got 0x%0h", label, want, got);
      fails++;
    end
  endfunction

  always @(posedge clk) begin
    result_t calc;
    result_t due;
    result_t seen;
    if (!rst) begin
      if (s_tvalid && s_tready) begin
        bytes_taken++;
        if (predict_summary(s_tdata, s_tlast, calc))
          summaries_due.push_back(cur_typed ? cur_want : calc);
      end
      if (m_tvalid && m_tready) begin
        seen = m_tdata[RESULT_BITS-1:0];
        if (summaries_due.size() == 0) begin
          $error("Summary 0x%0h arrived with none outstanding.", seen);
          fails++;
        end else begin
          due = summaries_due.pop_front();
          check_field("is_hid", due.is_hid, seen.is_hid);
          check_field("appearance", due.appearance, seen.appearance);
          check_field("flags_present", due.flags_present, seen.flags_present);
          check_field("adv_flags", due.adv_flags, seen.adv_flags);
          check_field("name_found", due.name_found, seen.name_found);
          check_field("name_offset", due.name_offset, seen.name_offset);
          check_field("name_length", due.name_length, seen.name_length);
          check_field("name_is_full", due.name_is_full, seen.name_is_full);
        end
        sums_checked++;
        if (seen.is_hid) hid_sums++;
        if (seen.name_found) named_sums++;
      end
    end
  end

  // The output side holds off once per raised hold request, then returns to random stalls.
  always @(negedge clk) begin
    if (hold_go && hold_cnt < LONG_HOLD) begin
      m_tready <= 1'b0;
      hold_cnt <= hold_cnt + 1;
    end else begin
      m_tready <= ($urandom_range(99) >= snk_stall_pct);
      if (!hold_go) hold_cnt <= 0;
    end
  end

  task automatic put_byte(input logic [7:0] d, input logic l, input logic typed,
                          input result_t want);
    while (src_idle_pct != 0 && $urandom_range(99) < src_idle_pct) begin
      s_tvalid <= 1'b0;
      @(negedge clk);
    end
    s_tdata <= d;
    s_tlast <= l;
    cur_typed <= typed;
    cur_want <= want;
    s_tvalid <= 1'b1;
    do @(posedge clk); while (!s_tready);
    @(negedge clk);
  endtask

  task automatic build_packet();
    int fields;
    int plen;
    int pick;
    int goal;
    logic [7:0] kind;
    logic [7:0] pay[256];
    logic [15:0] look;
    pkt_bytes.delete();
    if ($urandom_range(9) == 0) begin
      repeat ($urandom_range(1, 8)) pkt_bytes.push_back(8'($urandom_range(255)));
      return;
    end
    fields = $urandom_range(1, 5);
    repeat (fields) begin
      pick = $urandom_range(9);
      plen = ($urandom_range(39) == 0) ? $urandom_range(6, 254) : $urandom_range(0, 4);
      case (pick)
        0: kind = TYPE_FLAGS;
        1: kind = TYPE_UUID16_SOME;
        2: kind = TYPE_UUID16_ALL;
        3: kind = TYPE_NAME_SHORT;
        4: kind = TYPE_NAME_FULL;
        5, 6: kind = TYPE_APPEARANCE;
        default: kind = 8'($urandom_range(255));
      endcase
      if (pick == 9) begin
        pkt_bytes.push_back(8'h00);
      end else begin
        for (int k = 0; k < plen; k++) pay[k] = 8'($urandom_range(255));
        if (kind == TYPE_UUID16_SOME || kind == TYPE_UUID16_ALL) begin
          for (int k = 0; k + 1 < plen; k += 2) begin
            if ($urandom_range(2) == 0) begin
              pay[k] = UUID_HID[7:0];
              pay[k + 1] = UUID_HID[15:8];
            end
          end
        end
        if (kind == TYPE_APPEARANCE && plen >= 2 && $urandom_range(1) == 0) begin
          look = {HID_CATEGORY, 6'($urandom_range(63))};
          pay[0] = look[7:0];
          pay[1] = look[15:8];
        end
        pkt_bytes.push_back(8'(plen + 1));
        pkt_bytes.push_back(kind);
        for (int k = 0; k < plen; k++) pkt_bytes.push_back(pay[k]);
      end
    end
    if ($urandom_range(7) == 0)
      repeat ($urandom_range(0, pkt_bytes.size() - 1)) void'(pkt_bytes.pop_back());
    if ($urandom_range(39) == 0) begin
      goal = $urandom_range(256, 300);
      while (pkt_bytes.size() < goal) pkt_bytes.push_back(8'($urandom_range(255)));
    end
  endtask

  task automatic send_packet();
    if (pkt_bytes.size() > PKT_WINDOW) long_packets++;
    for (int i = 0; i < pkt_bytes.size(); i++)
      put_byte(pkt_bytes[i], i == pkt_bytes.size() - 1, 1'b0, '0);
    packets_sent++;
  endtask

  initial begin
    int target;
    int spin;
    repeat (12) @(posedge clk);
    @(negedge clk);
    rst <= 1'b0;
    @(negedge clk);

    for (int i = 0; i < DIR_ROWS; i++) begin
      put_byte(DIRECTED[i].data, DIRECTED[i].last, DIRECTED[i].typed, DIRECTED[i].want);
      if (DIRECTED[i].last) packets_sent++;
    end

    for (int phase = 0; phase < 4; phase++) begin
      case (phase)
        0: begin src_idle_pct = 0;  snk_stall_pct = 0;  end
        1: begin src_idle_pct = 48; snk_stall_pct = 0;  end
        2: begin src_idle_pct = 0;  snk_stall_pct = 48; end
        default: begin src_idle_pct = 37; snk_stall_pct = 37; end
      endcase
      target = bytes_taken + PHASE_BYTES;
      while (bytes_taken < target) begin
        build_packet();
        send_packet();
      end
    end

    // Single-byte packets pile up summaries while the output side is held off.
    src_idle_pct = 0;
    snk_stall_pct = 0;
    hold_go <= 1'b1;
    repeat (16) put_byte(8'($urandom_range(255)), 1'b1, 1'b0, '0);
    packets_sent += 16;
    hold_go <= 1'b0;

    src_idle_pct = 37;
    snk_stall_pct = 37;
    repeat (10) begin
      build_packet();
      send_packet();
      if (summaries_due.size() != 0) begin
        s_tvalid <= 1'b0;
        while (summaries_due.size() != 0) @(negedge clk);
      end
    end

    s_tvalid <= 1'b0;
    for (spin = 0; spin < 20000 && summaries_due.size() != 0; spin++) @(posedge clk);
    repeat (10) @(posedge clk);
    if (summaries_due.size() != 0) begin
      $error("%0d summaries never arrived.", summaries_due.size());
      fails++;
    end

    $display("Sent %0d packets (%0d past the parse window) as %0d bytes.",
             packets_sent, long_packets, bytes_taken);
    $display("Compared %0d summaries: %0d with HID, %0d with a name, through a long stall.",
             sums_checked, hid_sums, named_sums);
    if (fails == 0) begin
      $display("ALL CHECKS PASSED");
    end else begin
      $display("CHECKS FAILED");
    end
    $finish;
  end

  initial begin
    #1_000_000;
    $display("CHECKS FAILED");
    $finish;
  end

endmodule

[sim.f]
rtl/ble_adv_pkg.sv
rtl/ble_adv_data_parser.sv
dv/ble_adv_data_parser_tb.sv
